### rtl/core/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the three-wire SPI master core.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TIMER_W   = 12;
  localparam int unsigned BITCNT_W  = 5;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIFO_LEAD   = 1'b1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 12'd8;
  localparam logic [CFG_W-1:0] FIFO_LEAD_RST   = 12'd50;

  localparam logic [1:0] OP_REG_WRITE  = 2'd0;
  localparam logic [1:0] OP_REG_READ   = 2'd1;
  localparam logic [1:0] OP_FIFO_WRITE = 2'd2;
  localparam logic [1:0] OP_FIFO_READ  = 2'd3;

  typedef struct packed {
    logic              start_req;
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic              sdio_in;
  } tws_in_t;

  typedef struct packed {
    logic              csb;
    logic              fcsb;
    logic              sclk;
    logic              sdio_out;
    logic              sdio_drive;
    logic              busy_res;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
  } tws_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] half_period_ticks;
    logic [CFG_W-1:0] fifo_read_lead_ticks;
  } tws_cfg_t;

endpackage : tws_pkg

`default_nettype wire

### rtl/core/tws_cfg.sv
// ----------------------------------------------------------------------------
// tws_cfg
// Configuration register file: index decode and timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tws_pkg::CFG_W-1:0]     cfg_wdata,
  output tws_pkg::tws_cfg_t                  cfg
);
  import tws_pkg::*;

  logic [CFG_W-1:0] half_r, half_nxt;
  logic [CFG_W-1:0] lead_r, lead_nxt;

  always_comb begin
    half_nxt = half_r;
    lead_nxt = lead_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: half_nxt = cfg_wdata;
        CFG_FIFO_LEAD:   lead_nxt = cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RST;
      lead_r <= FIFO_LEAD_RST;
    end else begin
      half_r <= half_nxt;
      lead_r <= lead_nxt;
    end
  end

  assign cfg.half_period_ticks    = half_r;
  assign cfg.fifo_read_lead_ticks = lead_r;

endmodule : tws_cfg

`default_nettype wire

### rtl/core/tws_seq.sv
// ----------------------------------------------------------------------------
// tws_seq
// Pin sequencer: phase, timer and shift state, one tick per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  tws_pkg::tws_in_t  tick,
  input  tws_pkg::tws_cfg_t cfg,
  output tws_pkg::tws_out_t res
);
  import tws_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_LOW   = 6'b000100,
    PH_HIGH  = 6'b001000,
    PH_HOLD  = 6'b010000,
    PH_GUARD = 6'b100000
  } phase_t;

  localparam logic [BITCNT_W-1:0] BITS_BYTE  = 5'd8;
  localparam logic [BITCNT_W-1:0] BITS_FRAME = 5'd16;

  phase_t               phase_r, phase_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [BITCNT_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic [FRAME_W-1:0]   sout_r, sout_nxt;
  logic [BYTE_W-1:0]    sin_r, sin_nxt;
  logic [1:0]           op_r, op_nxt;

  function automatic logic reading_bit(input logic [1:0] op, input logic [BITCNT_W-1:0] bc);
    reading_bit = (op == OP_FIFO_READ) || ((op == OP_REG_READ) && (bc >= BITS_BYTE));
  endfunction

  always_comb begin
    logic [TIMER_W-1:0]  h;
    logic [TIMER_W-1:0]  lead;
    logic [BITCNT_W-1:0] total;
    logic [BITCNT_W-1:0] bc_inc;
    logic                done;
    logic                sel;
    logic                rvalid;

    h         = (cfg.half_period_ticks == '0) ? TIMER_W'(1) : cfg.half_period_ticks;
    lead      = '0;
    done      = (timer_r == '0);
    total     = op_r[1] ? BITS_BYTE : BITS_FRAME;
    bc_inc    = bitcnt_r + BITCNT_W'(1);
    rvalid    = 1'b0;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bitcnt_nxt = bitcnt_r;
    sout_nxt  = sout_r;
    sin_nxt   = sin_r;
    op_nxt    = op_r;

    if (en) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (tick.start_req) begin
            op_nxt     = tick.operation;
            bitcnt_nxt = '0;
            case (tick.operation)
              OP_REG_WRITE: begin
                sout_nxt = {1'b0, tick.address, tick.write_data};
                lead     = h;
              end
              OP_REG_READ: begin
                sout_nxt = {1'b1, tick.address, {BYTE_W{1'b1}}};
                lead     = h;
              end
              OP_FIFO_WRITE: begin
                sout_nxt = {tick.write_data, {BYTE_W{1'b1}}};
                lead     = '0;
              end
              default: begin
                sout_nxt = {FRAME_W{1'b1}};
                lead     = cfg.fifo_read_lead_ticks;
              end
            endcase
            if (lead != '0) begin
              phase_nxt = PH_LEAD;
              timer_nxt = lead - TIMER_W'(1);
            end else begin
              phase_nxt = PH_LOW;
              timer_nxt = h - TIMER_W'(1);
            end
          end
        end
        PH_LEAD, PH_LOW: begin
          if (done) begin
            phase_nxt = (phase_r == PH_LEAD) ? PH_LOW : PH_HIGH;
            timer_nxt = h - TIMER_W'(1);
          end else begin
            timer_nxt = timer_r - TIMER_W'(1);
          end
        end
        PH_HIGH: begin
          if (done) begin
            if (reading_bit(op_r, bitcnt_r)) begin
              sin_nxt = {sin_r[BYTE_W-2:0], tick.sdio_in};
            end
            sout_nxt = {sout_r[FRAME_W-2:0], 1'b1};
            if (bc_inc >= total) begin
              rvalid     = op_r[0];
              bitcnt_nxt = '0;
              if (op_r[1]) begin
                phase_nxt = PH_HOLD;
                timer_nxt = h - TIMER_W'(1);
              end else begin
                phase_nxt = PH_IDLE;
              end
            end else begin
              bitcnt_nxt = bc_inc;
              phase_nxt  = PH_LOW;
              timer_nxt  = h - TIMER_W'(1);
            end
          end else begin
            timer_nxt = timer_r - TIMER_W'(1);
          end
        end
        PH_HOLD, PH_GUARD: begin
          if (done) begin
            timer_nxt = h - TIMER_W'(1);
            if (bitcnt_r == '0) begin
              bitcnt_nxt = BITCNT_W'(1);
            end else begin
              bitcnt_nxt = '0;
              phase_nxt  = (phase_r == PH_HOLD) ? PH_GUARD : PH_IDLE;
            end
          end else begin
            timer_nxt = timer_r - TIMER_W'(1);
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // pin levels after this tick
    sel            = (phase_nxt != PH_IDLE) && (phase_nxt != PH_GUARD);
    res.csb        = !(sel && !op_nxt[1]);
    res.fcsb       = !(sel && op_nxt[1]);
    res.sclk       = 1'b0;
    res.sdio_out   = 1'b1;
    res.sdio_drive = !((phase_nxt != PH_IDLE) && (op_nxt == OP_FIFO_READ));
    if ((phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH)) begin
      res.sclk = (phase_nxt == PH_HIGH);
      if (reading_bit(op_nxt, bitcnt_nxt)) begin
        res.sdio_drive = 1'b0;
      end else begin
        res.sdio_out = sout_nxt[FRAME_W-1];
      end
    end
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.read_valid = rvalid;
    res.read_data  = sin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      timer_r  <= '0;
      bitcnt_r <= '0;
      sout_r   <= {FRAME_W{1'b1}};
      sin_r    <= '0;
      op_r     <= OP_REG_WRITE;
    end else begin
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      bitcnt_r <= bitcnt_nxt;
      sout_r   <= sout_nxt;
      sin_r    <= sin_nxt;
      op_r     <= op_nxt;
    end
  end

endmodule : tws_seq

`default_nettype wire

### rtl/core/three_wire_spi_master_core.sv
// ----------------------------------------------------------------------------
// three_wire_spi_master_core
// Three-wire half-duplex SPI master with register and FIFO transactions.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one timer tick; the core takes one
// per cycle unless stalled and returns one result transaction per tick,
// carrying the pin levels after that tick. A tick is held in the input
// register and is then stepped through the sequencer into the result
// register; while the result side stalls, the tick waits in the input register.
// Configuration writes take effect on the following cycle.
`default_nettype none

module three_wire_spi_master_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  tws_pkg::tws_in_t                   in_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output tws_pkg::tws_out_t                  out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tws_pkg::CFG_W-1:0]     cfg_wdata
);
  import tws_pkg::*;

  logic     s1_valid_r;
  tws_in_t  s1_data_r;
  logic     out_valid_r;
  tws_out_t out_data_r;
  logic     adv;
  tws_cfg_t cfg;
  tws_out_t step_res;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  tws_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tws_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .tick  (s1_data_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : three_wire_spi_master_core

`default_nettype wire

### rtl/core/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the SPI master core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input tws_pkg::tws_out_t      out_data
);
  import tws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed under stall");

  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.csb || out_data.fcsb)
    else $error("register and FIFO select low together");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      out_data.csb && out_data.fcsb && !out_data.sclk &&
      out_data.sdio_out && out_data.sdio_drive)
    else $error("pins not idle while not busy");

  a_read_clk_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> !out_data.sclk && out_data.csb)
    else $error("read completion with clock high or register select low");

endmodule : tws_checker

bind three_wire_spi_master_core tws_checker u_tws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-wire SPI master core. Every accepted tick
// updates a cycle-true model of the pin sequencer, and every result
// transaction is compared, field by field, with the oldest predicted pin
// state. A frame at the reset timing opens the test, directed frames cover
// the field extremes and each transaction kind, and random frames run with
// mixed sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import tws_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 40000;
  localparam int TICKS_PER_PHASE = 20;

  localparam int SDIO_LOW    = 0;
  localparam int SDIO_HIGH   = 1;
  localparam int SDIO_RANDOM = 2;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_LEAD, SEQ_LOW, SEQ_HIGH, SEQ_HOLD, SEQ_GUARD
  } seq_phase_e;

  class spi_pin_scoreboard;
    logic [CFG_W-1:0]    half_ticks;
    logic [CFG_W-1:0]    lead_ticks;
    seq_phase_e          phase;
    logic [TIMER_W-1:0]  timer;
    logic [BITCNT_W-1:0] bits;
    logic [FRAME_W-1:0]  frame;
    logic [BYTE_W-1:0]   rx_byte;
    logic [1:0]          op;
    tws_out_t            pin_states[$];
    int unsigned         errors;

    function new();
      half_ticks = HALF_PERIOD_RST;
      lead_ticks = FIFO_LEAD_RST;
      phase      = SEQ_IDLE;
      timer      = '0;
      bits       = '0;
      frame      = '1;
      rx_byte    = '0;
      op         = OP_REG_WRITE;
      errors     = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_HALF_PERIOD) begin
        half_ticks = val;
      end else begin
        lead_ticks = val;
      end
    endfunction

    function bit busy();
      return phase != SEQ_IDLE;
    endfunction

    function int unsigned pending();
      return pin_states.size();
    endfunction

    function bit is_fifo();
      return op == OP_FIFO_WRITE || op == OP_FIFO_READ;
    endfunction

    function bit reading();
      return op == OP_FIFO_READ || (op == OP_REG_READ && bits >= 8);
    endfunction

    function bit timer_expired();
      if (timer == 0) return 1'b1;
      timer = timer - 1'b1;
      return 1'b0;
    endfunction

    function void note_tick(tws_in_t t);
      logic [TIMER_W-1:0] h;
      logic [TIMER_W-1:0] lead;
      tws_out_t           p;
      int unsigned        total;
      h            = (half_ticks == 0) ? TIMER_W'(1) : half_ticks;
      p            = '0;
      p.csb        = 1'b1;
      p.fcsb       = 1'b1;
      p.sdio_out   = 1'b1;
      p.sdio_drive = 1'b1;
      case (phase)
        SEQ_IDLE: begin
          if (t.start_req) begin
            op   = t.operation;
            bits = '0;
            case (t.operation)
              OP_REG_WRITE: begin
                frame = {1'b0, t.address, t.write_data};
                lead  = h;
              end
              OP_REG_READ: begin
                frame = {1'b1, t.address, 8'hFF};
                lead  = h;
              end
              OP_FIFO_WRITE: begin
                frame = {t.write_data, 8'hFF};
                lead  = '0;
              end
              default: begin
                frame = '1;
                lead  = lead_ticks;
              end
            endcase
            if (lead != 0) begin
              phase = SEQ_LEAD;
              timer = lead - 1'b1;
            end else begin
              phase = SEQ_LOW;
              timer = h - 1'b1;
            end
          end
        end
        SEQ_LEAD, SEQ_LOW: begin
          if (timer_expired()) begin
            phase = (phase == SEQ_LEAD) ? SEQ_LOW : SEQ_HIGH;
            timer = h - 1'b1;
          end
        end
        SEQ_HIGH: begin
          if (timer_expired()) begin
            total = is_fifo() ? 8 : 16;
            if (reading()) rx_byte = {rx_byte[BYTE_W-2:0], t.sdio_in};
            frame = {frame[FRAME_W-2:0], 1'b1};
            bits  = bits + 1'b1;
            if (bits >= total) begin
              if (op == OP_REG_READ || op == OP_FIFO_READ) p.read_valid = 1'b1;
              bits = '0;
              if (is_fifo()) begin
                phase = SEQ_HOLD;
                timer = h - 1'b1;
              end else begin
                phase = SEQ_IDLE;
              end
            end else begin
              phase = SEQ_LOW;
              timer = h - 1'b1;
            end
          end
        end
        SEQ_HOLD, SEQ_GUARD: begin
          if (timer_expired()) begin
            timer = h - 1'b1;
            if (bits == 0) begin
              bits = BITCNT_W'(1);
            end else begin
              bits  = '0;
              phase = (phase == SEQ_HOLD) ? SEQ_GUARD : SEQ_IDLE;
            end
          end
        end
        default: phase = SEQ_IDLE;
      endcase

      if (phase != SEQ_IDLE) begin
        if (phase != SEQ_GUARD) begin
          if (is_fifo()) p.fcsb = 1'b0;
          else p.csb = 1'b0;
        end
        if (op == OP_FIFO_READ) p.sdio_drive = 1'b0;
        if (phase == SEQ_LOW || phase == SEQ_HIGH) begin
          p.sclk = (phase == SEQ_HIGH);
          if (reading()) p.sdio_drive = 1'b0;
          else p.sdio_out = frame[FRAME_W-1];
        end
      end
      p.busy_res  = (phase != SEQ_IDLE);
      p.read_data = rx_byte;
      pin_states.push_back(p);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(tws_out_t got);
      tws_out_t exp_pins;
      if (pin_states.size() == 0) begin
        $error("result transaction with no pin state expected");
        errors++;
        return;
      end
      exp_pins = pin_states.pop_front();
      cmp_field("csb", 8'(exp_pins.csb), 8'(got.csb));
      cmp_field("fcsb", 8'(exp_pins.fcsb), 8'(got.fcsb));
      cmp_field("sclk", 8'(exp_pins.sclk), 8'(got.sclk));
      cmp_field("sdio_out", 8'(exp_pins.sdio_out), 8'(got.sdio_out));
      cmp_field("sdio_drive", 8'(exp_pins.sdio_drive), 8'(got.sdio_drive));
      cmp_field("busy_res", 8'(exp_pins.busy_res), 8'(got.busy_res));
      cmp_field("read_valid", 8'(exp_pins.read_valid), 8'(got.read_valid));
      cmp_field("read_data", exp_pins.read_data, got.read_data);
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tws_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tws_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned cycles     = 0;
  int unsigned ticks_sent = 0;

  spi_pin_scoreboard sb = new();

  three_wire_spi_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL three_wire_spi_master_core");
      $finish;
    end
  end

  function automatic logic sdio_level(int mode);
    if (mode == SDIO_LOW) return 1'b0;
    if (mode == SDIO_HIGH) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic tws_in_t random_tick(int mode);
    tws_in_t t;
    t.start_req  = 1'($urandom_range(1));
    t.operation  = 2'($urandom_range(3));
    t.address    = 7'($urandom_range(127));
    t.write_data = 8'($urandom_range(255));
    t.sdio_in    = sdio_level(mode);
    return t;
  endfunction

  // enter and leave at a falling edge; valid stays high after acceptance
  task automatic send_tick(input tws_in_t t);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        sb.note_tick(t);
        taken = 1'b1;
      end
      @(negedge clk);
    end
    ticks_sent++;
  endtask

  task automatic finish_frame(input int mode);
    while (sb.busy()) send_tick(random_tick(mode));
  endtask

  task automatic run_frame(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] wdata, input int mode);
    tws_in_t t;
    finish_frame(SDIO_RANDOM);
    t.start_req  = 1'b1;
    t.operation  = op;
    t.address    = addr;
    t.write_data = wdata;
    t.sdio_in    = sdio_level(mode);
    send_tick(t);
    finish_frame(mode);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    finish_frame(SDIO_RANDOM);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    sb.set_cfg(idx, val);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] lead);
    write_cfg(CFG_HALF_PERIOD, half);
    write_cfg(CFG_FIFO_LEAD, lead);
  endtask

  task automatic random_frames(input int unsigned n);
    int unsigned target;
    tws_in_t     t;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      if ($urandom_range(99) < 85) begin
        run_frame(2'($urandom_range(3)), 7'($urandom_range(127)),
                  8'($urandom_range(255)), SDIO_RANDOM);
        repeat ($urandom_range(3)) begin
          t = random_tick(SDIO_RANDOM);
          t.start_req = 1'b0;
          send_tick(t);
        end
      end else begin
        // broken frames: starts at random points, finished by the next frame
        repeat ($urandom_range(1, 6)) send_tick(random_tick(SDIO_RANDOM));
      end
    end
  endtask

  task automatic random_phase();
    set_timing(12'($urandom_range(1)), 12'($urandom_range(2)));
    random_frames(TICKS_PER_PHASE / 2);
    set_timing(12'($urandom_range(1, 2)), 12'($urandom_range(2)));
    random_frames(TICKS_PER_PHASE / 2);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct   = 26;
    stall_pct = 81;
    // reset timing: default half period and FIFO read lead
    run_frame(OP_FIFO_READ, 7'h00, 8'h00, SDIO_RANDOM);

    // zero half period acts as one, zero lead skips the lead phase
    set_timing(12'd0, 12'd0);
    run_frame(OP_REG_WRITE, 7'h7F, 8'h00, SDIO_RANDOM);
    run_frame(OP_REG_WRITE, 7'h00, 8'hFF, SDIO_RANDOM);
    run_frame(OP_REG_READ, 7'h7F, 8'h00, SDIO_LOW);
    run_frame(OP_FIFO_WRITE, 7'h55, 8'hA5, SDIO_RANDOM);
    run_frame(OP_FIFO_READ, 7'h00, 8'hFF, SDIO_HIGH);

    gap_pct   = 81;
    stall_pct = 26;
    random_phase();

    gap_pct   = 0;
    stall_pct = 0;
    random_phase();
    finish_frame(SDIO_RANDOM);
    wait_drained();

    if (sb.errors == 0) begin
      $display("PASS three_wire_spi_master_core");
    end else begin
      $display("FAIL three_wire_spi_master_core");
    end
    $finish;
  end

endmodule
